// ===== rtl/assert_macros.svh =====
// assertion helper macros shared by the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mmm_pkg.sv =====
// shared constants and types for the montgomery multiplier
// no dependencies
`timescale 1ns / 1ps

package mmm_pkg;

  // default datapath word width
  localparam int WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int RES_W  = 32;
  localparam int OPND_W = 32;
  localparam int CFG_W  = 32;
  localparam int KBIT_W = 6;

  // width of one multiplier digit handled by a cell
  localparam int DIG_W = 8;

  // register reset values
  localparam logic [OPND_W-1:0] MODULUS_RST     = 32'd3;
  localparam logic [KBIT_W-1:0] R_BITS_RST      = 6'd32;
  localparam logic [OPND_W-1:0] NEG_INVERSE_RST = 32'h5555_5555;
  localparam logic [OPND_W-1:0] R_SQUARED_RST   = 32'd1;

  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_R_BITS      = 2'd1,
    REG_NEG_INVERSE = 2'd2,
    REG_R_SQUARED   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_MUL       = 2'd0,
    CMD_TO_MONT   = 2'd1,
    CMD_FROM_MONT = 2'd2
  } cmd_t;

endpackage

// ===== rtl/mmm_cell.sv =====
// one multiply-accumulate cell of the chain: adds multiplicand * digit at a fixed offset
// depends on mmm_pkg
`timescale 1ns / 1ps

module mmm_cell #(
  parameter int ACC_W  = 64,
  parameter int PASS_W = 64,
  parameter int MC_W   = 32,
  parameter int SHIFT  = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ACC_W-1:0]          acc_in,
  input  logic [PASS_W-1:0]         pass_in,
  input  logic [mmm_pkg::DIG_W-1:0] digit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ACC_W-1:0]          acc_out,
  output logic [PASS_W-1:0]         pass_out
);

  localparam int PROD_W = MC_W + mmm_pkg::DIG_W;
  localparam int EXT_W  = ACC_W + PROD_W;

  logic [PROD_W-1:0] prod;
  logic [EXT_W-1:0]  term;
  logic [ACC_W-1:0]  acc_next;

  // partial product of the multiplicand with this cell's digit
  assign prod     = PROD_W'(pass_in[MC_W-1:0]) * PROD_W'(digit);
  assign term     = EXT_W'(prod) << SHIFT;
  assign acc_next = acc_in + term[ACC_W-1:0];

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_out  <= acc_next;
      pass_out <= pass_in;
    end
  end

endmodule

// ===== rtl/mmm_reduce.sv =====
// final reduction: shift right by the radix exponent, then one conditional subtraction
// depends on mmm_pkg
`timescale 1ns / 1ps

module mmm_reduce #(
  parameter int SUM_W = 97,
  parameter int OPW   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SUM_W-1:0]           sum,
  input  logic [mmm_pkg::KBIT_W-1:0] k,
  input  logic [OPW-1:0]             p,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mmm_pkg::RES_W-1:0]  result
);

  localparam int TEXT_W = SUM_W + mmm_pkg::RES_W;

  logic                          shf_valid;
  logic                          shf_ready;
  logic [SUM_W-1:0]              shifted;
  logic [TEXT_W-1:0]             shifted_ext;
  logic                          take_sub;
  logic [mmm_pkg::RES_W-1:0]     result_next;

  // stage 1: variable right shift
  assign in_ready = !shf_valid || shf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shf_valid <= 1'b0;
    end else if (in_ready) begin
      shf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      shifted <= sum >> k;
    end
  end

  // stage 2: compare with p and subtract once, low bits kept
  assign shifted_ext = TEXT_W'(shifted);
  assign take_sub    = shifted >= SUM_W'(p);
  assign result_next = take_sub ?
                       (shifted_ext[mmm_pkg::RES_W-1:0] - mmm_pkg::RES_W'(p)) :
                       shifted_ext[mmm_pkg::RES_W-1:0];

  assign shf_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shf_ready) begin
      out_valid <= shf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shf_valid && shf_ready) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/montgomery_modular_multiply.sv =====
// top level of the montgomery modular multiplier (redc)
// depends on mmm_pkg, mmm_cell, mmm_reduce and assert_macros.svh
`timescale 1ns / 1ps
//
// usage
// - request channel: cmd, operand_a, operand_b with req_valid / req_ready;
//   cmd multiply gives a*b/R mod P, to-montgomery uses r_squared as b,
//   from-montgomery uses 1 as b, the unused code acts as multiply
// - result channel: result with res_valid / res_ready, one result per request
// - config port: cfg_we, cfg_index, cfg_data; write only while no request
//   is in flight, takes effect on the next cycle
// - datapath: three chains of ND = ceil(min(WORD_BITS,32)/8) cells each
//   (a*b, then q = mu*x mod R, then x + P*q), each cell folds in one 8-bit
//   digit of the multiplier, followed by a shift stage and a subtract stage
// - throughput: one request per cycle while the result channel is not stalled,
//   every stage holds its own request and hands it on when the next can take it
// - stall: a stage holds its request while the next one cannot take it; bubbles
//   close up, so requests are taken until every stage is occupied
// - reset: clears all stage valid bits and loads the register defaults
//   (modulus 3, r_bits 32, neg_inverse 0x55555555, r_squared 1)
//
`include "assert_macros.svh"

module montgomery_modular_multiply #(
  parameter int WORD_BITS = mmm_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mmm_pkg::CFG_W-1:0]  cfg_data,
  // requests
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 cmd,
  input  logic [mmm_pkg::OPND_W-1:0] operand_a,
  input  logic [mmm_pkg::OPND_W-1:0] operand_b,
  // results
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [mmm_pkg::RES_W-1:0]  result
);

  // operand width after masking to the word
  localparam int OPW     = (WORD_BITS < mmm_pkg::OPND_W) ? WORD_BITS : mmm_pkg::OPND_W;
  // widest radix exponent, and so the width of q
  localparam int QW      = (WORD_BITS < 63) ? WORD_BITS : 63;
  localparam int XW      = 2 * OPW;
  localparam int MC2_W   = (XW < QW) ? XW : QW;
  localparam int SUM_W   = OPW + QW + 1;
  localparam int ND      = (OPW + mmm_pkg::DIG_W - 1) / mmm_pkg::DIG_W;
  localparam int MUL_W   = ND * mmm_pkg::DIG_W;
  localparam int PASS1_W = 2 * OPW;

  // configuration registers
  logic [mmm_pkg::OPND_W-1:0] modulus;
  logic [mmm_pkg::KBIT_W-1:0] r_bits;
  logic [mmm_pkg::OPND_W-1:0] neg_inverse;
  logic [mmm_pkg::OPND_W-1:0] r_squared;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= mmm_pkg::MODULUS_RST;
      r_bits      <= mmm_pkg::R_BITS_RST;
      neg_inverse <= mmm_pkg::NEG_INVERSE_RST;
      r_squared   <= mmm_pkg::R_SQUARED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmm_pkg::REG_MODULUS:     modulus     <= cfg_data;
        mmm_pkg::REG_R_BITS:      r_bits      <= cfg_data[mmm_pkg::KBIT_W-1:0];
        mmm_pkg::REG_NEG_INVERSE: neg_inverse <= cfg_data;
        mmm_pkg::REG_R_SQUARED:   r_squared   <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived constants; the user keeps them stable while requests are in flight, the block does not enforce it
  logic [OPW-1:0]             p_word;
  logic [OPW-1:0]             mu_word;
  logic [MUL_W-1:0]           p_pad;
  logic [MUL_W-1:0]           mu_pad;
  logic [mmm_pkg::KBIT_W-1:0] k_eff;
  logic [QW-1:0]              k_mask;

  assign p_word  = modulus[OPW-1:0];
  assign mu_word = neg_inverse[OPW-1:0];
  assign p_pad   = MUL_W'(p_word);
  assign mu_pad  = MUL_W'(mu_word);

  // radix exponent clamped to the word width
  assign k_eff  = ({1'b0, r_bits} > 7'(WORD_BITS)) ? mmm_pkg::KBIT_W'(WORD_BITS) : r_bits;
  assign k_mask = ~({QW{1'b1}} << k_eff);

  // second operand chosen by the command
  logic [OPW-1:0] b_sel;

  always_comb begin
    case (cmd)
      mmm_pkg::CMD_TO_MONT:   b_sel = r_squared[OPW-1:0];
      mmm_pkg::CMD_FROM_MONT: b_sel = OPW'(1);
      default:                b_sel = operand_b[OPW-1:0];
    endcase
  end

  // chain one: x = a * b, b digits carried alongside a
  logic                v1   [ND+1];
  logic                r1   [ND+1];
  logic [XW-1:0]       acc1 [ND+1];
  logic [PASS1_W-1:0]  pas1 [ND+1];

  assign v1[0]   = req_valid;
  assign req_ready = r1[0];
  assign acc1[0] = '0;
  assign pas1[0] = {b_sel, operand_a[OPW-1:0]};

  // chain two: q = mu * x mod 2^QW, x carried
  logic                v2   [ND+1];
  logic                r2   [ND+1];
  logic [QW-1:0]       acc2 [ND+1];
  logic [XW-1:0]       pas2 [ND+1];

  assign v2[0]   = v1[ND];
  assign r1[ND]  = r2[0];
  assign acc2[0] = '0;
  assign pas2[0] = acc1[ND];

  // chain three: x + P * q, with q cut to k bits
  logic                v3   [ND+1];
  logic                r3   [ND+1];
  logic [SUM_W-1:0]    acc3 [ND+1];
  logic [QW-1:0]       pas3 [ND+1];

  assign v3[0]   = v2[ND];
  assign r2[ND]  = r3[0];
  assign acc3[0] = SUM_W'(pas2[ND]);
  assign pas3[0] = acc2[ND] & k_mask;

  for (genvar j = 0; j < ND; j++) begin : g_chain
    logic [MUL_W-1:0]            b_pad;
    logic [mmm_pkg::DIG_W-1:0]   dig1;
    logic [mmm_pkg::DIG_W-1:0]   dig2;
    logic [mmm_pkg::DIG_W-1:0]   dig3;

    assign b_pad = MUL_W'(pas1[j][PASS1_W-1:OPW]);
    assign dig1  = b_pad[j*mmm_pkg::DIG_W +: mmm_pkg::DIG_W];
    assign dig2  = mu_pad[j*mmm_pkg::DIG_W +: mmm_pkg::DIG_W];
    assign dig3  = p_pad[j*mmm_pkg::DIG_W +: mmm_pkg::DIG_W];

    mmm_cell #(
      .ACC_W (XW),
      .PASS_W(PASS1_W),
      .MC_W  (OPW),
      .SHIFT (j * mmm_pkg::DIG_W)
    ) u_mul_ab (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v1[j]),
      .in_ready (r1[j]),
      .acc_in   (acc1[j]),
      .pass_in  (pas1[j]),
      .digit    (dig1),
      .out_valid(v1[j+1]),
      .out_ready(r1[j+1]),
      .acc_out  (acc1[j+1]),
      .pass_out (pas1[j+1])
    );

    mmm_cell #(
      .ACC_W (QW),
      .PASS_W(XW),
      .MC_W  (MC2_W),
      .SHIFT (j * mmm_pkg::DIG_W)
    ) u_mul_q (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v2[j]),
      .in_ready (r2[j]),
      .acc_in   (acc2[j]),
      .pass_in  (pas2[j]),
      .digit    (dig2),
      .out_valid(v2[j+1]),
      .out_ready(r2[j+1]),
      .acc_out  (acc2[j+1]),
      .pass_out (pas2[j+1])
    );

    mmm_cell #(
      .ACC_W (SUM_W),
      .PASS_W(QW),
      .MC_W  (QW),
      .SHIFT (j * mmm_pkg::DIG_W)
    ) u_mul_pq (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v3[j]),
      .in_ready (r3[j]),
      .acc_in   (acc3[j]),
      .pass_in  (pas3[j]),
      .digit    (dig3),
      .out_valid(v3[j+1]),
      .out_ready(r3[j+1]),
      .acc_out  (acc3[j+1]),
      .pass_out (pas3[j+1])
    );
  end

  // shift by k and final conditional subtraction
  mmm_reduce #(
    .SUM_W(SUM_W),
    .OPW  (OPW)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3[ND]),
    .in_ready (r3[ND]),
    .sum      (acc3[ND]),
    .k        (k_eff),
    .p        (p_word),
    .out_valid(res_valid),
    .out_ready(res_ready),
    .result   (result)
  );

  // an accepted request lands in the first cell
  `ASSERT_NEXT(a_req_lands, clk, rst, req_valid && req_ready, v1[1])
  // an empty first cell always takes a request
  `ASSERT_IMPLIES(a_empty_takes, clk, rst, !v1[1], req_ready)
  // the clamped exponent never exceeds the word width
  `ASSERT_IMPLIES(a_k_clamped, clk, rst, 1'b1, ({1'b0, k_eff} <= 7'(WORD_BITS)))
  // a radix write is visible on the next cycle
  `ASSERT_NEXT(a_rbits_write, clk, rst,
               cfg_we && (cfg_index == mmm_pkg::REG_R_BITS),
               r_bits == $past(cfg_data[mmm_pkg::KBIT_W-1:0]))

endmodule
